FILE: rtl/core/masm_pkg.sv
// package for the matrix add / subtract / multiply engine
// field widths, parameter defaults and the issue tag shared by top level and datapath
// no dependencies
`timescale 1ns / 1ps

package masm_pkg;

  localparam int DIM_DEFAULT        = 4;
  localparam int ELEM_WIDTH_DEFAULT = 32;

  localparam int IN_W   = 32;
  localparam int IDX_W  = 3;
  localparam int SUM_W  = 33;
  localparam int PROD_W = 64;

  // control that travels with one multiply-accumulate step
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             take_a;
    logic             take_b;
    logic             final_cell;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } issue_tag_t;

endpackage

FILE: rtl/core/masm_datapath.sv
// element memories for A and B, multiplier and accumulator
// depends on masm_pkg
`timescale 1ns / 1ps

module masm_datapath
  import masm_pkg::*;
#(
  parameter int DIM        = DIM_DEFAULT,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_a,
  input  logic                          wr_b,
  input  logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] wr_addr,
  input  logic [ELEM_WIDTH-1:0]         wr_data,
  input  logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] rd_addr_a,
  input  logic [((DIM*DIM > 1) ? $clog2(DIM*DIM) : 1)-1:0] rd_addr_b,
  input  issue_tag_t                    issue,
  output logic                          busy,
  output logic                          finish,
  output logic [IDX_W-1:0]              row_index,
  output logic [IDX_W-1:0]              col_index,
  output logic signed [SUM_W-1:0]       sum_value,
  output logic signed [SUM_W-1:0]       diff_value,
  output logic signed [PROD_W-1:0]      product_value,
  output logic                          last_result
);

  localparam int CELLS = DIM * DIM;
  localparam int EW    = ELEM_WIDTH;

  logic [EW-1:0] mem_a [CELLS];
  logic [EW-1:0] mem_b [CELLS];

  logic signed [EW-1:0]     a_rd;
  logic signed [EW-1:0]     b_rd;
  logic signed [EW-1:0]     a_cell;
  logic signed [EW-1:0]     b_cell;
  logic signed [2*EW-1:0]   prod;
  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] acc_next;
  issue_tag_t               s1;
  issue_tag_t               s2;

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (wr_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    a_rd <= mem_a[rd_addr_a];
    b_rd <= mem_b[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= issue;
      s2 <= s1;
    end
  end

  // the cell's own A and B elements show up on the k == col and k == row steps
  always_ff @(posedge clk) begin
    if (s1.valid) begin
      prod <= a_rd * b_rd;
      if (s1.take_a) begin
        a_cell <= a_rd;
      end
      if (s1.take_b) begin
        b_cell <= b_rd;
      end
    end
  end

  assign acc_next = (s2.first ? '0 : acc) + PROD_W'(prod);

  always_ff @(posedge clk) begin
    if (s2.valid) begin
      acc <= acc_next;
      if (s2.last) begin
        product_value <= acc_next;
        sum_value     <= SUM_W'(a_cell) + SUM_W'(b_cell);
        diff_value    <= SUM_W'(a_cell) - SUM_W'(b_cell);
        row_index     <= s2.row;
        col_index     <= s2.col;
        last_result   <= s2.final_cell;
      end
    end
  end

  assign busy   = s1.valid | s2.valid;
  assign finish = s2.valid & s2.last;

endmodule

FILE: rtl/core/matrix_add_sub_mul_engine.sv
// top level of the matrix add / subtract / multiply engine: load and result sequencing
// depends on masm_pkg and masm_datapath
`timescale 1ns / 1ps

//  channel   handshake                    payload
//  element   element_valid/element_ready  element_value
//  result    result_valid/result_ready    row_index, col_index, sum_value, diff_value,
//                                         product_value, last_result
//
// loading takes one word per cycle, 2*DIM*DIM words per run
// each result is built from DIM reads on the element memories and passes the read,
// multiply and accumulate registers into the output register
// a new result is started only once the previous one has left the output register
// element_ready is high only while loading; synchronous reset returns to loading with
// no words held, the memory contents stay undefined until written

module matrix_add_sub_mul_engine
  import masm_pkg::*;
#(
  parameter int DIM        = DIM_DEFAULT,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     element_valid,
  output logic                     element_ready,
  input  logic signed [IN_W-1:0]   element_value,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [IDX_W-1:0]         row_index,
  output logic [IDX_W-1:0]         col_index,
  output logic signed [SUM_W-1:0]  sum_value,
  output logic signed [SUM_W-1:0]  diff_value,
  output logic signed [PROD_W-1:0] product_value,
  output logic                     last_result
);

  localparam int CELLS = DIM * DIM;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int LW    = $clog2(2 * CELLS);
  localparam int RW    = (DIM > 1) ? $clog2(DIM) : 1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WAIT,
    ST_RUN
  } state_t;

  state_t        state;
  logic [LW-1:0] load_cnt;
  logic [RW-1:0] r;
  logic [RW-1:0] c;
  logic [RW-1:0] k;

  logic          in_take;
  logic          load_b;
  logic          wr_a;
  logic          wr_b;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr_a;
  logic [AW-1:0] rd_addr_b;
  issue_tag_t    issue;
  logic          busy;
  logic          finish;
  logic          k_end;
  logic          c_end;
  logic          r_end;

  assign element_ready = (state == ST_LOAD);
  assign in_take       = element_valid & element_ready;
  assign load_b        = (load_cnt >= LW'(CELLS));
  assign wr_a          = in_take & ~load_b;
  assign wr_b          = in_take & load_b;
  assign wr_addr       = load_b ? AW'(load_cnt - LW'(CELLS)) : AW'(load_cnt);

  assign k_end = (k == RW'(DIM - 1));
  assign c_end = (c == RW'(DIM - 1));
  assign r_end = (r == RW'(DIM - 1));

  assign rd_addr_a = AW'(r) * AW'(DIM) + AW'(k);
  assign rd_addr_b = AW'(k) * AW'(DIM) + AW'(c);

  always_comb begin
    issue            = '0;
    issue.valid      = (state == ST_RUN);
    issue.first      = (k == '0);
    issue.last       = k_end;
    issue.take_a     = (k == c);
    issue.take_b     = (k == r);
    issue.final_cell = r_end & c_end;
    issue.row        = IDX_W'(r);
    issue.col        = IDX_W'(c);
  end

  // loading and reading never overlap: reads are issued only in the run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      load_cnt     <= '0;
      r            <= '0;
      c            <= '0;
      k            <= '0;
      result_valid <= 1'b0;
    end else begin
      if (finish) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_LOAD: begin
          if (in_take) begin
            if (load_cnt == LW'(2 * CELLS - 1)) begin
              load_cnt <= '0;
              r        <= '0;
              c        <= '0;
              k        <= '0;
              state    <= ST_WAIT;
            end else begin
              load_cnt <= load_cnt + 1'b1;
            end
          end
        end
        ST_WAIT: begin
          if (!result_valid && !busy) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (k_end) begin
            k <= '0;
            if (c_end) begin
              c <= '0;
              if (r_end) begin
                r     <= '0;
                state <= ST_LOAD;
              end else begin
                r     <= r + 1'b1;
                state <= ST_WAIT;
              end
            end else begin
              c     <= c + 1'b1;
              state <= ST_WAIT;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  masm_datapath #(
    .DIM        (DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .wr_a          (wr_a),
    .wr_b          (wr_b),
    .wr_addr       (wr_addr),
    .wr_data       (element_value[ELEM_WIDTH-1:0]),
    .rd_addr_a     (rd_addr_a),
    .rd_addr_b     (rd_addr_b),
    .issue         (issue),
    .busy          (busy),
    .finish        (finish),
    .row_index     (row_index),
    .col_index     (col_index),
    .sum_value     (sum_value),
    .diff_value    (diff_value),
    .product_value (product_value),
    .last_result   (last_result)
  );

endmodule

FILE: tb/tb_matrix_add_sub_mul_engine.sv
// self-checking testbench for the matrix add / subtract / multiply engine
// streams element words through matrix_add_sub_mul_engine and checks every result word
// depends on masm_pkg and the engine rtl
`timescale 1ns / 1ps

module tb_matrix_add_sub_mul_engine;
  import masm_pkg::*;

  localparam int DIM             = DIM_DEFAULT;
  localparam int ELEM_WIDTH      = ELEM_WIDTH_DEFAULT;
  localparam int CELLS           = DIM * DIM;
  localparam int IDLE_LIMIT      = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TAIL_CYCLES     = 4 * (DIM + 4) + 20;

  localparam logic [IN_W-1:0] ELEM_MIN = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic [IN_W-1:0] ELEM_MAX = {1'b0, {(IN_W-1){1'b1}}};

  typedef struct {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  diff;
    logic signed [PROD_W-1:0] prod;
    logic                     is_last;
  } cell_result_t;

  logic                     clk;
  logic                     rst;
  logic                     element_valid;
  logic                     element_ready;
  logic signed [IN_W-1:0]   element_value;
  logic                     result_valid;
  logic                     result_ready;
  logic [IDX_W-1:0]         row_index;
  logic [IDX_W-1:0]         col_index;
  logic signed [SUM_W-1:0]  sum_value;
  logic signed [SUM_W-1:0]  diff_value;
  logic signed [PROD_W-1:0] product_value;
  logic                     last_result;

  // matrices as held by the engine, sign extended
  longint       a_cells[CELLS];
  longint       b_cells[CELLS];
  int           words_loaded;
  cell_result_t expected_cells[$];

  int mismatch_count;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;

  matrix_add_sub_mul_engine #(
    .DIM        (DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .element_valid (element_valid),
    .element_ready (element_ready),
    .element_value (element_value),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .row_index     (row_index),
    .col_index     (col_index),
    .sum_value     (sum_value),
    .diff_value    (diff_value),
    .product_value (product_value),
    .last_result   (last_result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint sext_word(logic [IN_W-1:0] w);
    longint x;
    x = longint'($signed(w));
    // bits above ELEM_WIDTH are ignored by the engine
    x = (x <<< (64 - ELEM_WIDTH)) >>> (64 - ELEM_WIDTH);
    return x;
  endfunction

  // stores one word; the last word of B yields the whole result matrix
  function automatic void load_matrix_word(logic [IN_W-1:0] w);
    cell_result_t r;
    longint       acc;
    int           idx;
    if (words_loaded < CELLS) begin
      a_cells[words_loaded] = sext_word(w);
    end else begin
      b_cells[words_loaded - CELLS] = sext_word(w);
    end
    words_loaded++;
    if (words_loaded == 2 * CELLS) begin
      words_loaded = 0;
      for (int row = 0; row < DIM; row++) begin
        for (int col = 0; col < DIM; col++) begin
          idx = row * DIM + col;
          acc = 0;
          for (int k = 0; k < DIM; k++) begin
            acc += a_cells[row * DIM + k] * b_cells[k * DIM + col];
          end
          r.row     = IDX_W'(row);
          r.col     = IDX_W'(col);
          r.sum     = SUM_W'(a_cells[idx] + b_cells[idx]);
          r.diff    = SUM_W'(a_cells[idx] - b_cells[idx]);
          r.prod    = acc;
          r.is_last = (idx == CELLS - 1);
          expected_cells = {expected_cells, r};
        end
      end
    end
  endfunction

  function automatic logic [IN_W-1:0] random_element();
    logic [IN_W-1:0] w;
    case ($urandom_range(7))
      0: w = ELEM_MIN;
      1: w = ELEM_MAX;
      2: begin
        w = $urandom_range(32);
        w = w - 16;
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  task automatic send_element(logic [IN_W-1:0] w);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      element_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    element_valid <= 1'b1;
    element_value <= w;
    do @(posedge clk); while (!element_ready);
    load_matrix_word(w);
  endtask

  task automatic send_random_run();
    repeat (2 * CELLS) send_element(random_element());
  endtask

  // rows and columns of min, max, zero, one and minus one; the first product wraps to zero
  task automatic test_directed_extremes();
    logic [IN_W-1:0] w;
    int              row;
    int              col;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < CELLS; i++) begin
      row = i / DIM;
      col = i % DIM;
      case (row % 4)
        0: w = ELEM_MIN;
        1: w = ELEM_MAX;
        2: w = (col % 2) ? '1 : '0;
        default: w = (col % 2) ? IN_W'(1) : ELEM_MIN;
      endcase
      send_element(w);
    end
    for (int i = 0; i < CELLS; i++) begin
      row = i / DIM;
      col = i % DIM;
      case (col % 4)
        0: w = ELEM_MIN;
        1: w = ELEM_MAX;
        2: w = '1;
        default: w = (row % 2) ? ELEM_MIN : ELEM_MAX;
      endcase
      send_element(w);
    end
  endtask

  task automatic test_random_runs(int runs, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (runs) send_random_run();
  endtask

  // results back up while the sender keeps offering the next run
  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_OFF_CYCLES;
    repeat (2) send_random_run();
  endtask

  task automatic test_pause_until_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 30;
    send_random_run();
    @(negedge clk);
    element_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    send_random_run();
  endtask

  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cell_result_t exp;
    if (!rst && result_valid && result_ready) begin
      if (expected_cells.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result word: row %0d col %0d", row_index, col_index);
        end
      end else begin
        exp = expected_cells.pop_front();
        if (row_index !== exp.row || col_index !== exp.col || sum_value !== exp.sum ||
            diff_value !== exp.diff || product_value !== exp.prod ||
            last_result !== exp.is_last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected row %0d col %0d sum %0d diff %0d prod %0d last %0b",
                     exp.row, exp.col, exp.sum, exp.diff, exp.prod, exp.is_last);
            $display("          actual   row %0d col %0d sum %0d diff %0d prod %0d last %0b",
                     row_index, col_index, sum_value, diff_value, product_value,
                     last_result);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (element_valid && element_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst            = 1'b1;
    element_valid  = 1'b0;
    element_value  = '0;
    result_ready   = 1'b0;
    words_loaded   = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    hold_left      = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_extremes();
    test_random_runs(2, 0, 0);
    test_random_runs(2, 80, 0);
    test_random_runs(2, 0, 80);
    test_random_runs(2, 15, 15);
    test_output_hold_off();
    test_pause_until_drained();

    @(negedge clk);
    element_valid  <= 1'b0;
    recv_stall_pct = 0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_cells.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
